// ===== hdl/filtered_sensor_table_linearizer_assert.svh =====
// Assertion macros for the sensor table linearizer
`ifndef FILTERED_SENSOR_TABLE_LINEARIZER_ASSERT_SVH
`define FILTERED_SENSOR_TABLE_LINEARIZER_ASSERT_SVH

// same-cycle implication, clocked on clk, off during rst
`define FSTL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// next-cycle implication, clocked on clk, off during rst
`define FSTL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

// ===== hdl/fstl_pkg.sv =====
// Shared constants, calibration table and divider handshake types
`default_nettype none

package fstl_pkg;

  localparam int TABLE_ENTRIES = 52;
  localparam int AVERAGE_TAPS  = 5;
  localparam int MAX_BURST     = 1024;

  localparam int SAMPLE_W = 12;
  localparam int TEMP_W   = 15;
  localparam int COUNT_W  = 11;
  localparam int TOTAL_W  = 22;
  localparam int IDX_W    = $clog2(TABLE_ENTRIES);
  localparam int SLOT_W   = (AVERAGE_TAPS > 1) ? $clog2(AVERAGE_TAPS) : 1;
  localparam int SUM_W    = $clog2(AVERAGE_TAPS * 4095 + 1);

  // floor(sum / AVERAGE_TAPS) == (sum * RECIP) >> RECIP_SH over the sum range
  localparam int RECIP_SH = SUM_W + $clog2(AVERAGE_TAPS);
  localparam int RECIP_W  = RECIP_SH + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SH) + AVERAGE_TAPS - 1) / AVERAGE_TAPS);

  localparam int DVD_W = TOTAL_W;
  localparam int DVR_W = COUNT_W;

  localparam logic [SAMPLE_W-1:0] RAW_MAX = {SAMPLE_W{1'b1}};

  localparam int ADDR_W = 3;
  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  localparam logic             MODE_RESET  = 1'b1;
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(16);

  localparam logic [SAMPLE_W-1:0] CAL_X [TABLE_ENTRIES] = '{
    12'd541,  12'd544,  12'd561,  12'd601,  12'd628,  12'd707,  12'd743,
    12'd777,  12'd798,  12'd860,  12'd888,  12'd943,  12'd976,  12'd1008,
    12'd1044, 12'd1076, 12'd1123, 12'd1152, 12'd1194, 12'd1198, 12'd1235,
    12'd1270, 12'd1312, 12'd1384, 12'd1422, 12'd1462, 12'd1493, 12'd1507,
    12'd1555, 12'd1600, 12'd1646, 12'd1677, 12'd1718, 12'd1747, 12'd1793,
    12'd1834, 12'd1871, 12'd1905, 12'd1947, 12'd1982, 12'd2005, 12'd2055,
    12'd2089, 12'd2119, 12'd2164, 12'd2199, 12'd2231, 12'd2283, 12'd2337,
    12'd2353, 12'd2389, 12'd2433
  };

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [SAMPLE_W-1:0] cal_x(input logic [IDX_W-1:0] i);
    logic [SAMPLE_W-1:0] v;
    v = CAL_X[TABLE_ENTRIES-1];
    if (int'(i) < TABLE_ENTRIES) v = CAL_X[i];
    return v;
  endfunction

  // 18.5 C at the first point, then whole degrees from 19 C
  function automatic logic [TEMP_W-1:0] cal_t(input logic [IDX_W-1:0] i);
    logic [TEMP_W-1:0] t;
    t = TEMP_W'(4736);
    if (i != '0) t = TEMP_W'((TEMP_W'(18) + TEMP_W'(i)) << 8);
    return t;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/filtered_sensor_table_linearizer.sv =====
// Top level: sample filter, burst averager and calibration-table interpolator
//
//   channel | handshake              | payload                          | direction
//   in      | in_valid, in_stall     | adc_sample                       | into the block
//   out     | out_valid, out_stall   | temperature_q8, converted_raw    | out of the block
//   cfg     | psel, penable, pready  | pwrite, paddr, pwdata, prdata    | register access
//
// Direct mode: a reading at or past a table end skips the table search and the divide.
// Averaged mode: only the beat that closes a burst runs on to a result; the others end after the filter.
// The serial divider (for the burst mean and again for the interpolation) and the table
// search (up to 6 halving steps plus one to start the divide) make up the work of a beat.
// After rst a pass clears every slot of the filter ring; in_stall stays high meanwhile.
// One beat is in work at a time; a finished result holds while out_stall blocks the output.
`default_nettype none

module filtered_sensor_table_linearizer (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [fstl_pkg::SAMPLE_W-1:0]   adc_sample,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [fstl_pkg::TEMP_W-1:0]     temperature_q8,
  output logic      [fstl_pkg::SAMPLE_W-1:0]   converted_raw,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [fstl_pkg::ADDR_W-1:0]     paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic                                 pready
);

`include "filtered_sensor_table_linearizer_assert.svh"

  localparam logic [3:0] ST_CLR  = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_RD   = 4'd2;
  localparam logic [3:0] ST_FILT = 4'd3;
  localparam logic [3:0] ST_CHK  = 4'd4;
  localparam logic [3:0] ST_MEAN = 4'd5;
  localparam logic [3:0] ST_CONV = 4'd6;
  localparam logic [3:0] ST_SRCH = 4'd7;
  localparam logic [3:0] ST_INTP = 4'd8;
  localparam logic [3:0] ST_DONE = 4'd9;

  localparam int PROD_W = fstl_pkg::SUM_W + fstl_pkg::RECIP_W;
  localparam int MUL_W  = fstl_pkg::SAMPLE_W + fstl_pkg::TEMP_W;

  logic [3:0]                       state;
  logic [3:0]                       state_next;

  logic                             averaging_mode;
  logic [fstl_pkg::COUNT_W-1:0]     sample_count;

  logic [fstl_pkg::SLOT_W-1:0]      ring_slot;
  logic [fstl_pkg::SLOT_W-1:0]      clr_idx;
  logic [fstl_pkg::SUM_W-1:0]       ring_sum;
  logic [fstl_pkg::TOTAL_W-1:0]     running_total;
  logic [fstl_pkg::COUNT_W-1:0]     samples_taken;
  logic [fstl_pkg::SAMPLE_W-1:0]    sample;
  logic [fstl_pkg::SAMPLE_W-1:0]    raw;
  logic [fstl_pkg::IDX_W-1:0]       lo;
  logic [fstl_pkg::IDX_W-1:0]       hi;
  logic [fstl_pkg::TEMP_W-1:0]      temp;

  logic                             ram_we;
  logic [fstl_pkg::SLOT_W-1:0]      ram_waddr;
  logic [fstl_pkg::SAMPLE_W-1:0]    ram_wdata;
  logic [fstl_pkg::SAMPLE_W-1:0]    ram_rdata;

  fstl_pkg::div_req_t               div_req;
  fstl_pkg::div_rsp_t               div_rsp;

  logic                             in_take;
  logic                             out_load;
  logic                             cfg_wr;
  logic                             reg_sel;
  logic [fstl_pkg::COUNT_W-1:0]     count_eff;
  logic [PROD_W-1:0]                filt_prod;
  logic [fstl_pkg::SAMPLE_W-1:0]    filt;
  logic [fstl_pkg::IDX_W-1:0]       mid;
  logic                             seg_found;
  logic [fstl_pkg::SAMPLE_W-1:0]    seg_off;
  logic [fstl_pkg::TEMP_W-1:0]      seg_rise;
  logic [MUL_W-1:0]                 seg_prod;
  logic [fstl_pkg::SAMPLE_W-1:0]    seg_span;

  // configuration port
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_sel)
      fstl_pkg::REG_MODE:  prdata = {31'd0, averaging_mode};
      fstl_pkg::REG_COUNT: prdata = {{(32 - fstl_pkg::COUNT_W){1'b0}}, sample_count};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      averaging_mode <= fstl_pkg::MODE_RESET;
      sample_count   <= fstl_pkg::COUNT_RESET;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        fstl_pkg::REG_MODE:  averaging_mode <= pwdata[0];
        fstl_pkg::REG_COUNT: sample_count   <= pwdata[fstl_pkg::COUNT_W-1:0];
        default:             averaging_mode <= averaging_mode;
      endcase
    end
  end

  // filter ring storage
  fstl_ram #(
    .WIDTH (fstl_pkg::SAMPLE_W),
    .DEPTH (fstl_pkg::AVERAGE_TAPS)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ring_slot),
    .rdata (ram_rdata)
  );

  assign ram_we    = (state == ST_CLR) || (state == ST_RD);
  assign ram_waddr = (state == ST_CLR) ? clr_idx : ring_slot;
  assign ram_wdata = (state == ST_CLR) ? '0 : sample;

  fstl_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_load = (state == ST_DONE) && (!out_valid || !out_stall);

  always_comb begin
    priority if (sample_count == '0) begin
      count_eff = fstl_pkg::COUNT_W'(1);
    end else if (sample_count > fstl_pkg::COUNT_W'(fstl_pkg::MAX_BURST)) begin
      count_eff = fstl_pkg::COUNT_W'(fstl_pkg::MAX_BURST);
    end else begin
      count_eff = sample_count;
    end
  end

  assign filt_prod = PROD_W'(ring_sum) * PROD_W'(fstl_pkg::RECIP);
  assign filt      = fstl_pkg::SAMPLE_W'(filt_prod >> fstl_pkg::RECIP_SH);

  assign mid       = fstl_pkg::IDX_W'(({1'b0, lo} + {1'b0, hi}) >> 1);
  assign seg_found = (hi == lo + fstl_pkg::IDX_W'(1));
  assign seg_off   = raw - fstl_pkg::cal_x(lo);
  assign seg_rise  = fstl_pkg::cal_t(lo + fstl_pkg::IDX_W'(1)) - fstl_pkg::cal_t(lo);
  assign seg_prod  = MUL_W'(seg_off) * MUL_W'(seg_rise);
  assign seg_span  = fstl_pkg::cal_x(lo + fstl_pkg::IDX_W'(1)) - fstl_pkg::cal_x(lo);

  always_comb begin
    div_req = '0;
    if (state == ST_CHK) begin
      div_req.start    = (samples_taken >= count_eff);
      div_req.dividend = running_total;
      div_req.divisor  = count_eff;
    end else if (state == ST_SRCH) begin
      div_req.start    = seg_found;
      div_req.dividend = seg_prod[fstl_pkg::DVD_W-1:0];
      div_req.divisor  = fstl_pkg::DVR_W'(seg_span);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLR:  if (clr_idx == fstl_pkg::SLOT_W'(fstl_pkg::AVERAGE_TAPS - 1)) begin
                 state_next = ST_IDLE;
               end
      ST_IDLE: if (in_take) begin
                 state_next = averaging_mode ? ST_RD : ST_CONV;
               end
      ST_RD:   state_next = ST_FILT;
      ST_FILT: state_next = ST_CHK;
      ST_CHK:  state_next = div_req.start ? ST_MEAN : ST_IDLE;
      ST_MEAN: if (div_rsp.done) state_next = ST_CONV;
      ST_CONV: begin
        if (raw <= fstl_pkg::cal_x('0) || raw >= fstl_pkg::cal_x(fstl_pkg::LAST_IDX)) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_SRCH;
        end
      end
      ST_SRCH: if (seg_found) state_next = ST_INTP;
      ST_INTP: if (div_rsp.done) state_next = ST_DONE;
      ST_DONE: if (out_load) state_next = ST_IDLE;
      default: state_next = ST_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLR;
      clr_idx       <= '0;
      ring_slot     <= '0;
      ring_sum      <= '0;
      running_total <= '0;
      samples_taken <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLR) clr_idx <= clr_idx + fstl_pkg::SLOT_W'(1);
      if (state == ST_RD) begin
        ring_sum  <= ring_sum - fstl_pkg::SUM_W'(ram_rdata) + fstl_pkg::SUM_W'(sample);
        ring_slot <= (ring_slot == fstl_pkg::SLOT_W'(fstl_pkg::AVERAGE_TAPS - 1)) ?
                     '0 : ring_slot + fstl_pkg::SLOT_W'(1);
      end
      if (state == ST_FILT) begin
        running_total <= running_total + fstl_pkg::TOTAL_W'(filt);
        samples_taken <= samples_taken + fstl_pkg::COUNT_W'(1);
      end
      if (state == ST_MEAN && div_rsp.done) begin
        running_total <= '0;
        samples_taken <= '0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      sample <= adc_sample;
      raw    <= adc_sample;
    end
    if (state == ST_MEAN && div_rsp.done) begin
      raw <= (div_rsp.quotient > fstl_pkg::DVD_W'(fstl_pkg::RAW_MAX)) ?
             fstl_pkg::RAW_MAX : div_rsp.quotient[fstl_pkg::SAMPLE_W-1:0];
    end
    if (state == ST_CONV) begin
      lo <= '0;
      hi <= fstl_pkg::LAST_IDX;
      if (raw <= fstl_pkg::cal_x('0)) begin
        temp <= fstl_pkg::cal_t('0);
      end else begin
        temp <= fstl_pkg::cal_t(fstl_pkg::LAST_IDX);
      end
    end
    if (state == ST_SRCH && !seg_found) begin
      if (fstl_pkg::cal_x(mid) <= raw) begin
        lo <= mid;
      end else begin
        hi <= mid;
      end
    end
    if (state == ST_INTP && div_rsp.done) begin
      temp <= fstl_pkg::cal_t(lo) + div_rsp.quotient[fstl_pkg::TEMP_W-1:0];
    end
    if (out_load) begin
      temperature_q8 <= temp;
      converted_raw  <= raw;
    end
  end

  `FSTL_ASSERT_NOW(a_temp_range, out_valid,
    temperature_q8 >= fstl_pkg::TEMP_W'(4736) && temperature_q8 <= fstl_pkg::TEMP_W'(17664))
  `FSTL_ASSERT_NOW(a_slot_range, 1'b1,
    ring_slot <= fstl_pkg::SLOT_W'(fstl_pkg::AVERAGE_TAPS - 1))
  `FSTL_ASSERT_NOW(a_burst_bound, 1'b1,
    samples_taken <= fstl_pkg::COUNT_W'(fstl_pkg::MAX_BURST))
  `FSTL_ASSERT_NEXT(a_avg_path, in_take && averaging_mode, state == ST_RD)

endmodule

`default_nettype wire

// ===== hdl/fstl_ram.sv =====
// Generic single-write, registered-read RAM
`default_nettype none

module fstl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/fstl_div.sv =====
// Restoring divider, one quotient bit per cycle
`default_nettype none

module fstl_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire fstl_pkg::div_req_t req,
  output fstl_pkg::div_rsp_t     rsp
);

  localparam int CNT_W = $clog2(fstl_pkg::DVD_W + 1);

  logic                          busy;
  logic [CNT_W-1:0]              cnt;
  logic [fstl_pkg::DVD_W-1:0]    dvd;
  logic [fstl_pkg::DVR_W-1:0]    rem;
  logic [fstl_pkg::DVR_W-1:0]    dsr;
  logic                          done;
  logic [fstl_pkg::DVR_W:0]      shifted;
  logic                          ge;

  assign shifted = {rem, dvd[fstl_pkg::DVD_W-1]};
  assign ge      = shifted >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(fstl_pkg::DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dsr <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? fstl_pkg::DVR_W'(shifted - {1'b0, dsr}) : shifted[fstl_pkg::DVR_W-1:0];
      dvd <= {dvd[fstl_pkg::DVD_W-2:0], ge};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = dvd;

endmodule

`default_nettype wire
